@@ sv/ssti_pkg.sv @@
// package: types, character codes and helpers shared by the string-to-integer parser
package ssti_pkg;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned BASE_W   = 6;
    localparam int unsigned DIGIT_W  = 6;
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned OFFSET_W = 16;

    typedef logic [CH_W-1:0]            t_char;
    typedef logic [BASE_W-1:0]          t_base;
    typedef logic [DIGIT_W-1:0]         t_digit;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic [OFFSET_W-1:0]        t_offset;

    localparam t_char CH_MINUS  = 8'h2D;
    localparam t_char CH_PLUS   = 8'h2B;
    localparam t_char CH_ZERO   = 8'h30;
    localparam t_char CH_NINE   = 8'h39;
    localparam t_char CH_UP_A   = 8'h41;
    localparam t_char CH_UP_Z   = 8'h5A;
    localparam t_char CH_LO_A   = 8'h61;
    localparam t_char CH_LO_Z   = 8'h7A;
    localparam t_char CH_UP_X   = 8'h58;
    localparam t_char CH_LO_X   = 8'h78;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_CR     = 8'h0D;

    localparam t_base BASE_AUTO  = 6'd0;
    localparam t_base BASE_OCT   = 6'd8;
    localparam t_base BASE_DEC   = 6'd10;
    localparam t_base BASE_HEX   = 6'd16;

    localparam t_digit DIGIT_NONE = 6'd36;
    localparam t_digit DIGIT_TEN  = 6'd10;

    localparam t_offset OFFSET_MAX = '1;

    // status from the digit multiply-accumulate
    typedef struct packed {
        logic digit_ok;
        logic sat;
    } t_mac_flags;

    function automatic logic is_white(t_char c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic t_digit digit_of(t_char c);
        t_digit d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = DIGIT_W'(c - CH_UP_A) + DIGIT_TEN;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = DIGIT_W'(c - CH_LO_A) + DIGIT_TEN;
        end
        return d;
    endfunction

endpackage

@@ sv/ssti_in_if.sv @@
// interface: character item channel
interface ssti_in_if;
    logic               valid;
    logic               ready;
    ssti_pkg::t_char    ch;
    logic               first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

@@ sv/ssti_out_if.sv @@
// interface: converted result item channel
interface ssti_out_if;
    logic               valid;
    logic               ready;
    ssti_pkg::t_value   value;
    ssti_pkg::t_offset  end_offset;
    logic               overflow;

    modport source (output valid, output value, output end_offset, output overflow, input ready);
    modport sink   (input valid, input value, input end_offset, input overflow, output ready);
endinterface

@@ sv/ssti_digit_mac.sv @@
// digit decode and saturating multiply-accumulate of the magnitude
module ssti_digit_mac #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  ssti_pkg::t_char         i_ch,
    input  ssti_pkg::t_base         i_base,
    input  logic                    i_neg,
    input  logic                    i_sat,
    input  logic [VALUE_BITS-1:0]   i_acc,
    output logic [VALUE_BITS-1:0]   o_acc,
    output ssti_pkg::t_mac_flags    o_flags
);
    localparam int unsigned PROD_W = VALUE_BITS + ssti_pkg::BASE_W;

    ssti_pkg::t_digit   w_digit;
    logic [PROD_W-1:0]  w_sum;
    logic [PROD_W-1:0]  w_limit;

    assign w_digit = ssti_pkg::digit_of(i_ch);

    // acc*base + d > limit is the same test as acc > (limit - d) / base
    assign w_sum   = PROD_W'(i_acc) * PROD_W'(i_base) + PROD_W'(w_digit);
    assign w_limit = i_neg ? (PROD_W'(1) << (VALUE_BITS - 1))
                           : (PROD_W'(1) << (VALUE_BITS - 1)) - PROD_W'(1);

    always_comb begin
        o_flags.digit_ok = (w_digit != ssti_pkg::DIGIT_NONE)
                        && (w_digit < i_base)
                        && (i_base != ssti_pkg::BASE_AUTO);
        o_flags.sat      = i_sat;
        o_acc            = i_acc;
        if (!i_sat) begin
            if (w_sum > w_limit) begin
                o_flags.sat = 1'b1;
            end else begin
                o_acc = w_sum[VALUE_BITS-1:0];
            end
        end
    end
endmodule

@@ sv/signed_string_to_integer.sv @@
// top level: streaming strtol-style signed string to integer converter
// output: a result item is registered into the output register as the stopping character is taken
// throughput: one character item per cycle, set by the combinational digit multiply-accumulate,
// except that a full output register stalls input only while the waiting result is not taken
// reset: synchronous active low; parser waits for a first flag, base register returns to 10
// the result register is cleared to empty on reset
module signed_string_to_integer #(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  ssti_pkg::t_base     i_cfg_wdata,
    ssti_in_if.sink             i_in,
    ssti_out_if.source          o_res
);
    localparam int unsigned EXT_W = (COUNT_BITS > ssti_pkg::OFFSET_W) ? COUNT_BITS
                                                                       : ssti_pkg::OFFSET_W;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [VALUE_BITS-1:0] t_mag;

    localparam t_count COUNT_MAX = '1;

    // parser state
    t_phase             r_phase,  n_phase;
    logic               r_neg,    n_neg;
    ssti_pkg::t_base    r_base,   n_base;
    t_mag               r_acc,    n_acc;
    logic               r_sat,    n_sat;
    t_count             r_cc,     n_cc;
    t_count             r_ec,     n_ec;
    ssti_pkg::t_base    r_cfg_base;

    // output register
    logic               r_out_valid, n_out_valid;
    ssti_pkg::t_value   r_value,     n_value;
    ssti_pkg::t_offset  r_offset,    n_offset;
    logic               r_ovf,       n_ovf;

    // state as seen after a possible restart
    t_phase             w_phase;
    logic               w_neg;
    ssti_pkg::t_base    w_base;
    t_mag               w_acc;
    logic               w_sat;
    t_count             w_cc;
    t_count             w_ec;
    t_count             w_cc_inc;

    ssti_pkg::t_base    w_dig_base;
    t_mag               w_mac_acc;
    ssti_pkg::t_mac_flags w_mac;

    logic               w_in_take;
    logic               w_out_take;
    logic               w_in_ready;
    logic               w_zero_start;
    logic               w_is_x;

    // finishing values
    logic               w_emit;
    t_count             w_ec_stop;
    t_mag               w_fin_mag;
    logic [EXT_W-1:0]   w_ec_ext;

    assign w_in_ready = !r_out_valid || o_res.ready;
    assign w_in_take  = i_in.valid && w_in_ready;
    assign w_out_take = r_out_valid && o_res.ready;

    assign i_in.ready       = w_in_ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.value      = r_value;
    assign o_res.end_offset = r_offset;
    assign o_res.overflow   = r_ovf;

    // a first flag restarts the parser and samples the base register
    always_comb begin
        if (i_in.first) begin
            w_phase = PH_SPACE;
            w_neg   = 1'b0;
            w_base  = r_cfg_base;
            w_acc   = '0;
            w_sat   = 1'b0;
            w_cc    = '0;
            w_ec    = '0;
        end else begin
            w_phase = r_phase;
            w_neg   = r_neg;
            w_base  = r_base;
            w_acc   = r_acc;
            w_sat   = r_sat;
            w_cc    = r_cc;
            w_ec    = r_ec;
        end
    end

    assign w_cc_inc     = (w_cc == COUNT_MAX) ? w_cc : w_cc + t_count'(1);
    assign w_zero_start = (i_in.ch == ssti_pkg::CH_ZERO)
                       && ((w_base == ssti_pkg::BASE_AUTO) || (w_base == ssti_pkg::BASE_HEX));
    assign w_is_x       = (i_in.ch == ssti_pkg::CH_UP_X) || (i_in.ch == ssti_pkg::CH_LO_X);

    // base in force for a digit taken now: auto turns decimal, or octal after a leading zero
    always_comb begin
        w_dig_base = w_base;
        if (w_base == ssti_pkg::BASE_AUTO) begin
            w_dig_base = (w_phase == PH_ZERO) ? ssti_pkg::BASE_OCT : ssti_pkg::BASE_DEC;
        end
    end

    ssti_digit_mac #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mac (
        .i_ch    (i_in.ch),
        .i_base  (w_dig_base),
        .i_neg   (w_neg),
        .i_sat   (w_sat),
        .i_acc   (w_acc),
        .o_acc   (w_mac_acc),
        .o_flags (w_mac)
    );

    // parser step
    always_comb begin
        n_phase   = r_phase;
        n_neg     = r_neg;
        n_base    = r_base;
        n_acc     = r_acc;
        n_sat     = r_sat;
        n_cc      = r_cc;
        n_ec      = r_ec;
        w_emit    = 1'b0;
        w_ec_stop = w_ec;
        if (w_in_take) begin
            n_phase = w_phase;
            n_neg   = w_neg;
            n_base  = w_base;
            n_acc   = w_acc;
            n_sat   = w_sat;
            n_cc    = w_cc;
            n_ec    = w_ec;
            if (w_phase != PH_DONE) begin
                n_cc = w_cc_inc;
                unique case (w_phase)
                    PH_SPACE, PH_SIGNED: begin
                        if (w_phase == PH_SPACE && ssti_pkg::is_white(i_in.ch)) begin
                            // leading white space skipped
                        end else if (w_phase == PH_SPACE && i_in.ch == ssti_pkg::CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGNED;
                        end else if (w_phase == PH_SPACE && i_in.ch == ssti_pkg::CH_PLUS) begin
                            n_phase = PH_SIGNED;
                        end else if (w_zero_start) begin
                            // leading zero may open a hex prefix
                            n_phase = PH_ZERO;
                        end else begin
                            n_base  = w_dig_base;
                            n_phase = PH_DIGITS;
                            w_emit  = !w_mac.digit_ok;
                        end
                    end
                    PH_ZERO: begin
                        if (w_is_x) begin
                            n_base  = ssti_pkg::BASE_HEX;
                            n_phase = PH_DIGITS;
                        end else begin
                            // the zero counts as a digit
                            n_base    = w_dig_base;
                            n_phase   = PH_DIGITS;
                            n_ec      = w_cc;
                            w_ec_stop = w_cc;
                            w_emit    = !w_mac.digit_ok;
                        end
                    end
                    PH_DIGITS: begin
                        w_emit = !w_mac.digit_ok;
                    end
                    default: begin
                        w_emit = 1'b0;
                    end
                endcase
                // digit taken: accumulate and move the end mark
                if ((n_phase == PH_DIGITS) && !w_emit
                    && !(w_phase == PH_ZERO && w_is_x)
                    && !(w_phase == PH_SIGNED && w_zero_start)
                    && !(w_phase == PH_SPACE && (w_zero_start
                         || i_in.ch == ssti_pkg::CH_PLUS || i_in.ch == ssti_pkg::CH_MINUS
                         || ssti_pkg::is_white(i_in.ch)))) begin
                    n_acc = w_mac_acc;
                    n_sat = w_mac.sat;
                    n_ec  = w_cc_inc;
                end
                if (w_emit) begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    // result item from the state in force when the stopping character came
    always_comb begin
        if (w_neg) begin
            w_fin_mag = w_sat ? t_mag'(1) << (VALUE_BITS - 1) : t_mag'(0) - w_acc;
        end else begin
            w_fin_mag = w_sat ? (t_mag'(1) << (VALUE_BITS - 1)) - t_mag'(1) : w_acc;
        end
    end

    assign w_ec_ext = EXT_W'(w_ec_stop);

    always_comb begin
        n_out_valid = r_out_valid;
        n_value     = r_value;
        n_offset    = r_offset;
        n_ovf       = r_ovf;
        if (w_out_take) begin
            n_out_valid = 1'b0;
        end
        if (w_in_take && w_emit) begin
            n_out_valid = 1'b1;
            n_value     = ssti_pkg::t_value'($signed(w_fin_mag));
            n_offset    = (w_ec_ext > EXT_W'(ssti_pkg::OFFSET_MAX))
                        ? ssti_pkg::OFFSET_MAX : w_ec_ext[ssti_pkg::OFFSET_W-1:0];
            n_ovf       = w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DONE;
            r_neg       <= 1'b0;
            r_base      <= ssti_pkg::BASE_AUTO;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_cc        <= '0;
            r_ec        <= '0;
            r_cfg_base  <= ssti_pkg::BASE_DEC;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_base      <= n_base;
            r_acc       <= n_acc;
            r_sat       <= n_sat;
            r_cc        <= n_cc;
            r_ec        <= n_ec;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg_base <= i_cfg_wdata;
            end
        end
        r_value  <= n_value;
        r_offset <= n_offset;
        r_ovf    <= n_ovf;
    end
endmodule

@@ dv/tb_top.sv @@
// testbench: streaming string-to-integer parser checked against a cycle-free predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HALF_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES   = 5;
    localparam int unsigned RAND_ITEMS     = 450;
    localparam int unsigned LONG_DIGITS    = 80;     // far past the clamp point in decimal
    localparam int unsigned HOLD_CYCLES    = 300;    // receiver hold-off under pressure
    localparam int unsigned DRAIN_CYCLES   = 4;      // result register holds a single result
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned CNT_MAX        = 65535;
    localparam int unsigned DIGIT_LIMIT    = 36;

    localparam ssti_pkg::t_char CH_NUL      = 8'h00;
    localparam ssti_pkg::t_char CH_SEMI     = 8'h3B;
    localparam ssti_pkg::t_base BASE_UNARY  = 6'd1;
    localparam ssti_pkg::t_base BASE_BIN    = 6'd2;
    localparam ssti_pkg::t_base BASE_ALNUM  = 6'd36;
    localparam ssti_pkg::t_base BASE_ODD    = 6'd37;
    localparam ssti_pkg::t_base BASE_TOP    = 6'd63;
    localparam logic [63:0]     MAG_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // parser phases of the predictor
    typedef enum logic [2:0] {
        PS_LEADING,
        PS_SIGNED,
        PS_ZERO,
        PS_DIGITS,
        PS_DONE
    } t_parse_phase;

    // one converted number as the block should report it
    typedef struct {
        ssti_pkg::t_value  value;
        ssti_pkg::t_offset end_offset;
        logic              overflow;
    } t_conv_res;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    ssti_pkg::t_base i_cfg_wdata;

    ssti_in_if  in_ch ();
    ssti_out_if res_ch ();

    signed_string_to_integer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_res       (res_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state: base register copy plus the parser of one string
    // ------------------------------------------------------------------
    ssti_pkg::t_base cfg_base  = ssti_pkg::BASE_DEC;
    t_parse_phase    ps        = PS_DONE;
    logic            neg_sign  = 1'b0;
    int unsigned     run_base  = 0;
    logic [63:0]     mag       = '0;
    logic            mag_sat   = 1'b0;
    int unsigned     char_cnt  = 0;
    int unsigned     end_cnt   = 0;

    t_conv_res    pending_conv[$];   // conversions still owed by the block

    // run control shared by the stimulus and the receiver
    bit           tx_gaps_on   = 1'b1;
    bit           rx_stalls_on = 1'b1;
    bit           hold_req     = 1'b0;
    int unsigned  items_sent   = 0;
    int unsigned  mismatch_cnt = 0;
    int unsigned  quiet_cycles = 0;

    function automatic bit is_blank(ssti_pkg::t_char c);
        return (c == ssti_pkg::CH_SPACE) || (c >= ssti_pkg::CH_TAB && c <= ssti_pkg::CH_CR);
    endfunction

    // digit weight 0..35, or 36 for anything that is no digit at all
    function automatic int unsigned char_digit(ssti_pkg::t_char c);
        ssti_pkg::t_char folded;
        folded = c | 8'h20;   // upper case letters fold onto lower case
        if (c >= ssti_pkg::CH_ZERO && c <= ssti_pkg::CH_NINE) begin
            return c - ssti_pkg::CH_ZERO;
        end else if (folded >= ssti_pkg::CH_LO_A && folded <= ssti_pkg::CH_LO_Z) begin
            return folded - ssti_pkg::CH_LO_A + 10;
        end
        return DIGIT_LIMIT;
    endfunction

    // stopping character seen: one result, then ignore until the next first flag
    task automatic post_result();
        t_conv_res r;
        if (mag_sat) begin
            r.value = neg_sign ? ssti_pkg::t_value'({1'b1, 63'b0})
                               : ssti_pkg::t_value'(MAG_POS_MAX);
        end else begin
            r.value = neg_sign ? ssti_pkg::t_value'(-mag) : ssti_pkg::t_value'(mag);
        end
        r.end_offset = ssti_pkg::t_offset'(end_cnt);
        r.overflow   = mag_sat;
        pending_conv.push_back(r);
        ps = PS_DONE;
    endtask

    task automatic take_digit(ssti_pkg::t_char c);
        int unsigned d;
        logic [63:0] lim;
        d = char_digit(c);
        if (d >= DIGIT_LIMIT || d >= run_base || run_base == 0) begin
            post_result();
        end else begin
            // once clamped the digits are still consumed, only the offset moves
            if (!mag_sat) begin
                lim = neg_sign ? MAG_POS_MAX + 64'd1 : MAG_POS_MAX;
                if (mag > (lim - d) / run_base) begin
                    mag_sat = 1'b1;
                end else begin
                    mag = mag * run_base + d;
                end
            end
            end_cnt = char_cnt;
        end
    endtask

    task automatic start_number(ssti_pkg::t_char c);
        if (c == ssti_pkg::CH_ZERO &&
            (run_base == ssti_pkg::BASE_AUTO || run_base == ssti_pkg::BASE_HEX)) begin
            ps = PS_ZERO;   // could still become a 0x prefix
        end else begin
            if (run_base == ssti_pkg::BASE_AUTO) begin
                run_base = ssti_pkg::BASE_DEC;
            end
            ps = PS_DIGITS;
            take_digit(c);
        end
    endtask

    // advance the predictor by one accepted character item
    task automatic parse_char(ssti_pkg::t_char c, logic f);
        int unsigned pos;
        if (f) begin
            ps       = PS_LEADING;
            neg_sign = 1'b0;
            run_base = cfg_base;
            mag      = '0;
            mag_sat  = 1'b0;
            char_cnt = 0;
            end_cnt  = 0;
        end
        if (ps != PS_DONE) begin
            pos = char_cnt;
            if (char_cnt < CNT_MAX) begin
                char_cnt++;
            end
            case (ps)
                PS_LEADING: begin
                    if (!is_blank(c)) begin
                        if (c == ssti_pkg::CH_MINUS) begin
                            neg_sign = 1'b1;
                            ps = PS_SIGNED;
                        end else if (c == ssti_pkg::CH_PLUS) begin
                            ps = PS_SIGNED;
                        end else begin
                            start_number(c);
                        end
                    end
                end
                PS_SIGNED: begin
                    start_number(c);
                end
                PS_ZERO: begin
                    if (c == ssti_pkg::CH_UP_X || c == ssti_pkg::CH_LO_X) begin
                        // prefix: the zero no longer counts as a digit
                        run_base = ssti_pkg::BASE_HEX;
                        ps = PS_DIGITS;
                    end else begin
                        if (run_base == ssti_pkg::BASE_AUTO) begin
                            run_base = ssti_pkg::BASE_OCT;
                        end
                        end_cnt = pos;
                        ps = PS_DIGITS;
                        take_digit(c);
                    end
                end
                default: begin
                    take_digit(c);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // mostly short idle runs, now and then a long one
    function automatic int unsigned gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // offer one character item and wait for the handshake
    task automatic send_char(ssti_pkg::t_char c, logic f);
        int unsigned gap;
        gap = (tx_gaps_on && $urandom_range(0, 99) < 25) ? gap_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.ch    <= c;
        in_ch.first <= f;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        parse_char(c, f);
    endtask

    task automatic send_text(ssti_pkg::t_char txt[$]);
        for (int i = 0; i < txt.size(); i++) begin
            send_char(txt[i], i == 0);
        end
    endtask

    task automatic send_str(string s, bit add_nul);
        ssti_pkg::t_char txt[$];
        for (int i = 0; i < s.len(); i++) begin
            txt.push_back(ssti_pkg::t_char'(s[i]));
        end
        if (add_nul) begin
            txt.push_back(CH_NUL);
        end
        send_text(txt);
    endtask

    // block idle: every owed result taken and the output register flushed
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_conv.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(ssti_pkg::t_base b);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        cfg_base = b;
        i_cfg_we <= 1'b0;
    endtask

    // random string: mostly well formed for the current base, some noise
    task automatic make_text(output ssti_pkg::t_char txt[$]);
        int unsigned eff;
        int unsigned n;
        int unsigned r;
        int unsigned v;
        txt = {};
        if ($urandom_range(0, 9) == 0) begin
            // raw bytes, any code
            n = $urandom_range(1, 6);
            repeat (n) txt.push_back(ssti_pkg::t_char'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1) begin
                txt.push_back(CH_NUL);
            end
        end else begin
            if ($urandom_range(0, 99) < 30) begin
                repeat ($urandom_range(1, 3)) begin
                    v = $urandom_range(8, 13);
                    txt.push_back(v == 8 ? ssti_pkg::CH_SPACE : ssti_pkg::t_char'(v));
                end
            end
            case ($urandom_range(0, 2))
                1: txt.push_back(ssti_pkg::CH_PLUS);
                2: txt.push_back(ssti_pkg::CH_MINUS);
                default: ;
            endcase
            eff = (cfg_base == ssti_pkg::BASE_AUTO) ? ssti_pkg::BASE_DEC :
                  (cfg_base > DIGIT_LIMIT) ? DIGIT_LIMIT : cfg_base;
            if (cfg_base == ssti_pkg::BASE_AUTO || cfg_base == ssti_pkg::BASE_HEX) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    txt.push_back(ssti_pkg::CH_ZERO);
                    txt.push_back(r < 15 ? ssti_pkg::CH_LO_X : ssti_pkg::CH_UP_X);
                    eff = ssti_pkg::BASE_HEX;
                end else if (r < 50) begin
                    txt.push_back(ssti_pkg::CH_ZERO);
                    eff = (cfg_base == ssti_pkg::BASE_AUTO) ? ssti_pkg::BASE_OCT
                                                            : ssti_pkg::BASE_HEX;
                end
            end
            // a few digit runs long enough that some clamp even in binary
            r = $urandom_range(0, 99);
            n = (r < 5) ? $urandom_range(60, 70) :
                (r < 20) ? $urandom_range(14, 24) : $urandom_range(1, 8);
            repeat (n) begin
                v = ($urandom_range(0, 31) == 0) ? $urandom_range(0, DIGIT_LIMIT - 1)
                                                 : $urandom_range(0, eff - 1);
                if (v < 10) begin
                    txt.push_back(ssti_pkg::CH_ZERO + ssti_pkg::t_char'(v));
                end else begin
                    txt.push_back(($urandom_range(0, 1) ? ssti_pkg::CH_UP_A : ssti_pkg::CH_LO_A)
                                  + ssti_pkg::t_char'(v - 10));
                end
            end
            // terminator: NUL, any byte, or none so the next first flag cuts it short
            r = $urandom_range(0, 99);
            if (r < 35) begin
                txt.push_back(CH_NUL);
            end else if (r < 92) begin
                txt.push_back(ssti_pkg::t_char'($urandom_range(0, 255)));
            end
        end
        // trailing bytes, dropped by the parser if it has already stopped
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) txt.push_back(ssti_pkg::t_char'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // nothing started yet: these are dropped without a result
        send_char(ssti_pkg::CH_NINE, 1'b0);
        send_char(ssti_pkg::CH_ZERO, 1'b0);
        send_str(" \t-42", 1'b1);
        wait_drained();
        write_base(ssti_pkg::BASE_AUTO);
        send_str("0x1Fg", 1'b0);            // hex through the prefix
        send_str("0Xz", 1'b0);              // prefix with no hex digit after it
        send_str("0178", 1'b0);             // leading zero means octal
        send_str("+", 1'b1);                // sign only
        wait_drained();
        write_base(ssti_pkg::BASE_HEX);
        send_str("0ff!", 1'b0);             // leading zero is a hex digit here
        send_str("-8000000000000000", 1'b1);
        send_str("7FFFFFFFFFFFFFFF0", 1'b1);
        wait_drained();
        write_base(BASE_UNARY);
        send_str("001", 1'b1);              // base one takes only zeros
        wait_drained();
        write_base(BASE_TOP);
        send_str("-zZ.", 1'b0);
        send_char(8'hFF, 1'b1);
        send_str("- 5", 1'b1);
    endtask

    // long digit run: the value clamps and later digits still move the offset
    task automatic test_long_string();
        wait_drained();
        write_base(ssti_pkg::BASE_DEC);
        tx_gaps_on = 1'b0;
        send_char(ssti_pkg::CH_ZERO + 8'd1, 1'b1);
        repeat (LONG_DIGITS) send_char(ssti_pkg::CH_NINE, 1'b0);
        send_char(CH_NUL, 1'b0);
        tx_gaps_on = 1'b1;
    endtask

    // receiver holds off while single-digit strings keep coming back to back
    task automatic test_backpressure();
        wait_drained();
        write_base(ssti_pkg::BASE_DEC);
        tx_gaps_on = 1'b0;
        hold_req = 1'b1;
        repeat (40) begin
            send_char(ssti_pkg::CH_ZERO + ssti_pkg::t_char'($urandom_range(0, 9)), 1'b1);
            send_char(CH_SEMI, 1'b0);
        end
        tx_gaps_on = 1'b1;
    endtask

    // phases of random strings, each under its own base setting
    task automatic test_random();
        ssti_pkg::t_base base_plan [9] = '{ssti_pkg::BASE_AUTO, ssti_pkg::BASE_HEX,
                                           ssti_pkg::BASE_DEC, ssti_pkg::BASE_OCT, BASE_BIN,
                                           BASE_ALNUM, BASE_UNARY, BASE_ODD, BASE_TOP};
        ssti_pkg::t_char txt[$];
        int unsigned     first_item;
        int unsigned     phase_no;
        first_item = items_sent;
        phase_no   = 0;
        while (items_sent - first_item < RAND_ITEMS) begin
            wait_drained();
            write_base(phase_no < $size(base_plan) ? base_plan[phase_no]
                                                   : ssti_pkg::t_base'($urandom_range(0, 63)));
            // some phases run without any idling on one side or both
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            repeat (12) begin
                make_text(txt);
                send_text(txt);
            end
            phase_no++;
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.ch    <= '0;
        in_ch.first <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_long_string();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_conv.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // receiver: random stalls, plus the long hold-off when asked for
    initial begin : res_ready_ctl
        int unsigned stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // every accepted result against the oldest owed conversion
    always @(posedge i_clk) begin : res_check
        t_conv_res want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_conv.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("unexpected result item: value %0d offset %0d ovf %0b",
                             res_ch.value, res_ch.end_offset, res_ch.overflow);
                end
            end else begin
                want = pending_conv.pop_front();
                if (res_ch.value !== want.value || res_ch.end_offset !== want.end_offset ||
                    res_ch.overflow !== want.overflow) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("result mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 want.value, want.end_offset, want.overflow,
                                 res_ch.value, res_ch.end_offset, res_ch.overflow);
                    end
                end
            end
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
